// ===== design/rri_pkg.sv =====
// ----------------------------------------------------------------------------
// rri_pkg
// Shared widths, register map and pipeline bundles for the ray / rectangle
// intersection unit.
// ----------------------------------------------------------------------------
package rri_pkg;

    localparam int CW      = 32;             // coordinate width
    localparam int FB      = 16;             // fraction bits of coordinates
    localparam int TEX_FB  = 16;             // fraction bits of tex coordinates
    localparam int TEX_W   = TEX_FB + 1;
    localparam int MAT_W   = 16;
    localparam int AXIS_W  = 2;
    localparam int DIV_NW  = CW + FB + 1;    // dividend and quotient width
    localparam int DIV_DW  = CW + 1;         // divisor width
    localparam int TW      = DIV_NW + 1;     // signed plane parameter width
    localparam int PW      = 2 * CW - FB + 1; // hit point width before saturation
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REG_N   = 7;

    localparam logic [AXIS_W-1:0] AXIS_XY = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_XZ = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YZ = 2'd2;

    localparam logic [2:0] REG_AXIS     = 3'd0;
    localparam logic [2:0] REG_OFFSET   = 3'd1;
    localparam logic [2:0] REG_FIRST_LO = 3'd2;
    localparam logic [2:0] REG_FIRST_HI = 3'd3;
    localparam logic [2:0] REG_SECOND_LO = 3'd4;
    localparam logic [2:0] REG_SECOND_HI = 3'd5;
    localparam logic [2:0] REG_MATERIAL = 3'd6;

    localparam logic [CW-1:0] BOUND_HI_RESET = CW'(1) << FB;

    // travels beside the plane divider
    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
        logic [CW-1:0]      tmin;
        logic [CW-1:0]      tmax;
        logic               neg;
        logic               front;
        logic               miss;
    } t_side_t;

    // travels beside the texture dividers
    typedef struct packed {
        logic [CW-1:0]      t;
        logic [2:0][CW-1:0] p;
        logic               front;
        logic               miss;
        logic               u_zero;
        logic               v_zero;
    } t_side_tex;

endpackage

// ===== design/rri_div.sv =====
// ----------------------------------------------------------------------------
// rri_div
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rri_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [rri_pkg::DIV_NW-1:0] i_num,
    input  logic [rri_pkg::DIV_DW-1:0] i_den,
    output logic                      o_valid,
    output logic [rri_pkg::DIV_NW-1:0] o_quo
);
    import rri_pkg::*;

    logic              r_vld [DIV_NW];
    logic [DIV_DW-1:0] r_rem [DIV_NW];
    logic [DIV_NW-1:0] r_num [DIV_NW];
    logic [DIV_NW-1:0] r_quo [DIV_NW];
    logic [DIV_DW-1:0] r_den [DIV_NW];

    for (genvar s = 0; s < DIV_NW; s++) begin : g_stage
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_NW-1:0] num_in;
        logic [DIV_NW-1:0] quo_in;
        logic [DIV_DW-1:0] den_in;
        logic              vld_in;
        logic [DIV_DW:0]   shifted;
        logic [DIV_DW:0]   diff;
        logic              ge;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign num_in = r_num[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
            assign vld_in = r_vld[s-1];
        end

        assign shifted = {rem_in, num_in[DIV_NW-1]};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = shifted >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            r_num[s] <= {num_in[DIV_NW-2:0], 1'b0};
            r_quo[s] <= {quo_in[DIV_NW-2:0], ge};
            r_den[s] <= den_in;
        end
    end

    assign o_valid = r_vld[DIV_NW-1];
    assign o_quo   = r_quo[DIV_NW-1];

endmodule

// ===== design/rri_regs.sv =====
// ----------------------------------------------------------------------------
// rri_regs
// Configuration register file behind the apb port.
// ----------------------------------------------------------------------------
module rri_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rri_pkg::ADDR_W-1:0]  paddr,
    input  logic [rri_pkg::DATA_W-1:0]  pwdata,
    output logic [rri_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [rri_pkg::AXIS_W-1:0]  o_axis,
    output logic [rri_pkg::CW-1:0]      o_offset,
    output logic [rri_pkg::CW-1:0]      o_first_lo,
    output logic [rri_pkg::CW-1:0]      o_first_hi,
    output logic [rri_pkg::CW-1:0]      o_second_lo,
    output logic [rri_pkg::CW-1:0]      o_second_hi,
    output logic [rri_pkg::MAT_W-1:0]   o_material
);
    import rri_pkg::*;

    logic [AXIS_W-1:0] r_axis;
    logic [CW-1:0]     r_offset;
    logic [CW-1:0]     r_first_lo;
    logic [CW-1:0]     r_first_hi;
    logic [CW-1:0]     r_second_lo;
    logic [CW-1:0]     r_second_hi;
    logic [MAT_W-1:0]  r_material;
    logic              wr;
    logic [2:0]        idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis      <= AXIS_XY;
            r_offset    <= '0;
            r_first_lo  <= '0;
            r_first_hi  <= BOUND_HI_RESET;
            r_second_lo <= '0;
            r_second_hi <= BOUND_HI_RESET;
            r_material  <= '0;
        end else if (wr) begin
            case (idx)
                REG_AXIS:      r_axis      <= pwdata[AXIS_W-1:0];
                REG_OFFSET:    r_offset    <= pwdata[CW-1:0];
                REG_FIRST_LO:  r_first_lo  <= pwdata[CW-1:0];
                REG_FIRST_HI:  r_first_hi  <= pwdata[CW-1:0];
                REG_SECOND_LO: r_second_lo <= pwdata[CW-1:0];
                REG_SECOND_HI: r_second_hi <= pwdata[CW-1:0];
                REG_MATERIAL:  r_material  <= pwdata[MAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_AXIS:      prdata = DATA_W'(r_axis);
            REG_OFFSET:    prdata = DATA_W'(r_offset);
            REG_FIRST_LO:  prdata = DATA_W'(r_first_lo);
            REG_FIRST_HI:  prdata = DATA_W'(r_first_hi);
            REG_SECOND_LO: prdata = DATA_W'(r_second_lo);
            REG_SECOND_HI: prdata = DATA_W'(r_second_hi);
            REG_MATERIAL:  prdata = DATA_W'(r_material);
            default:       prdata = '0;
        endcase
    end

    assign o_axis      = r_axis;
    assign o_offset    = r_offset;
    assign o_first_lo  = r_first_lo;
    assign o_first_hi  = r_first_hi;
    assign o_second_lo = r_second_lo;
    assign o_second_hi = r_second_hi;
    assign o_material  = r_material;

endmodule

// ===== design/axis_rect_ray_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// axis_rect_ray_intersect_unit
// Pipelined ray test against one axis-aligned rectangle, Q16.16.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start / busy           i_origin_*, i_dir_*, i_t_min, i_t_max
//  result    o_done (one cycle)     o_hit, o_hit_t, o_tex_*, o_point_*, ...
//  config    apb psel/penable       paddr, pwdata, prdata
//
//  one request per cycle; busy is always low
//  from accept to o_done a request passes stages 1 and 2, the plane divider,
//  stages 3 to 6, the two texture dividers and the output register (49 stages per divider)
//  synchronous active-low reset empties the pipeline
//  no back-pressure: each result shows for exactly one cycle
// ----------------------------------------------------------------------------
module axis_rect_ray_intersect_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rri_pkg::CW-1:0]     i_origin_x,
    input  logic [rri_pkg::CW-1:0]     i_origin_y,
    input  logic [rri_pkg::CW-1:0]     i_origin_z,
    input  logic [rri_pkg::CW-1:0]     i_dir_x,
    input  logic [rri_pkg::CW-1:0]     i_dir_y,
    input  logic [rri_pkg::CW-1:0]     i_dir_z,
    input  logic [rri_pkg::CW-1:0]     i_t_min,
    input  logic [rri_pkg::CW-1:0]     i_t_max,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [rri_pkg::CW-1:0]     o_hit_t,
    output logic [rri_pkg::TEX_W-1:0]  o_tex_u,
    output logic [rri_pkg::TEX_W-1:0]  o_tex_v,
    output logic [rri_pkg::CW-1:0]     o_point_x,
    output logic [rri_pkg::CW-1:0]     o_point_y,
    output logic [rri_pkg::CW-1:0]     o_point_z,
    output logic                       o_front_face,
    output logic [rri_pkg::MAT_W-1:0]  o_hit_material,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rri_pkg::ADDR_W-1:0] paddr,
    input  logic [rri_pkg::DATA_W-1:0] pwdata,
    output logic [rri_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rri_pkg::*;

    logic [AXIS_W-1:0] axis;
    logic [CW-1:0]     offset, first_lo, first_hi, second_lo, second_hi;
    logic [MAT_W-1:0]  material;

    rri_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_axis(axis), .o_offset(offset), .o_first_lo(first_lo), .o_first_hi(first_hi),
        .o_second_lo(second_lo), .o_second_hi(second_hi), .o_material(material)
    );

    assign busy = 1'b0;

    // normal / in-plane axis indexes
    logic [1:0] ax_n, ax_a, ax_b;
    logic       ax_bad;
    always_comb begin
        ax_bad = 1'b0;
        case (axis)
            AXIS_XY: begin ax_n = 2'd2; ax_a = 2'd0; ax_b = 2'd1; end
            AXIS_XZ: begin ax_n = 2'd1; ax_a = 2'd0; ax_b = 2'd2; end
            AXIS_YZ: begin ax_n = 2'd0; ax_a = 2'd1; ax_b = 2'd2; end
            default: begin ax_n = 2'd0; ax_a = 2'd1; ax_b = 2'd2; ax_bad = 1'b1; end
        endcase
    end

    // stage 1: input capture
    logic               r_s1_vld;
    logic [2:0][CW-1:0] r_s1_org, r_s1_dir;
    logic [CW-1:0]      r_s1_tmin, r_s1_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_org  <= {i_origin_z, i_origin_y, i_origin_x};
        r_s1_dir  <= {i_dir_z, i_dir_y, i_dir_x};
        r_s1_tmin <= i_t_min;
        r_s1_tmax <= i_t_max;
    end

    // stage 2: numerator and divisor magnitudes
    logic signed [CW-1:0] dn;
    logic signed [CW:0]   num;
    logic [CW:0]          num_abs;
    logic [CW:0]          dn_abs;
    logic                 n_s2_neg;

    assign dn       = $signed(r_s1_dir[ax_n]);
    assign num      = $signed({offset[CW-1], offset}) -
                      $signed({r_s1_org[ax_n][CW-1], r_s1_org[ax_n]});
    assign num_abs  = num[CW] ? (CW+1)'(-num) : num;
    assign dn_abs   = dn[CW-1] ? (CW+1)'(-$signed({dn[CW-1], dn})) : {1'b0, dn};
    assign n_s2_neg = num[CW] ^ dn[CW-1];

    logic              r_s2_vld;
    logic [DIV_NW-1:0] r_s2_num;
    logic [DIV_DW-1:0] r_s2_den;
    t_side_t           r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_num        <= DIV_NW'(num_abs) << FB;
        r_s2_den        <= DIV_DW'(dn_abs);
        r_s2_side.org   <= r_s1_org;
        r_s2_side.dir   <= r_s1_dir;
        r_s2_side.tmin  <= r_s1_tmin;
        r_s2_side.tmax  <= r_s1_tmax;
        r_s2_side.neg   <= n_s2_neg;
        r_s2_side.front <= dn[CW-1];
        r_s2_side.miss  <= ax_bad || (dn == '0);
    end

    logic              t_vld;
    logic [DIV_NW-1:0] t_quo;

    rri_div u_div_t (
        .i_clk, .i_rst_n, .i_valid(r_s2_vld), .i_num(r_s2_num), .i_den(r_s2_den),
        .o_valid(t_vld), .o_quo(t_quo)
    );

    t_side_t r_sd1 [DIV_NW];
    always_ff @(posedge i_clk) begin
        r_sd1[0] <= r_s2_side;
        for (int k = 1; k < DIV_NW; k++) begin
            r_sd1[k] <= r_sd1[k-1];
        end
    end

    // stage 3: sign and interval test
    t_side_t            sd1;
    logic signed [TW-1:0] t_full;
    logic                 n_s3_out;

    assign sd1      = r_sd1[DIV_NW-1];
    assign t_full   = sd1.neg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
    assign n_s3_out = (t_full < $signed(TW'($signed(sd1.tmin)))) ||
                      (t_full > $signed(TW'($signed(sd1.tmax))));

    logic               r_s3_vld;
    logic [CW-1:0]      r_s3_t;
    logic [2:0][CW-1:0] r_s3_org, r_s3_dir;
    logic               r_s3_front, r_s3_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_t     <= t_full[CW-1:0];
        r_s3_org   <= sd1.org;
        r_s3_dir   <= sd1.dir;
        r_s3_front <= sd1.front;
        r_s3_miss  <= sd1.miss || n_s3_out;
    end

    // stage 4: t times direction
    logic                   r_s4_vld;
    logic [2:0][2*CW-1:0]   r_s4_prod;
    logic [CW-1:0]          r_s4_t;
    logic [2:0][CW-1:0]     r_s4_org;
    logic                   r_s4_front, r_s4_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s4_prod[i] <= $signed(r_s3_t) * $signed(r_s3_dir[i]);
        end
        r_s4_t     <= r_s3_t;
        r_s4_org   <= r_s3_org;
        r_s4_front <= r_s3_front;
        r_s4_miss  <= r_s3_miss;
    end

    // stage 5: hit point, floor shift is an arithmetic shift
    logic                 r_s5_vld;
    logic [2:0][PW-1:0]   r_s5_p;
    logic [CW-1:0]        r_s5_t;
    logic                 r_s5_front, r_s5_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s5_p[i] <= PW'($signed(r_s4_org[i])) +
                         PW'($signed(r_s4_prod[i][2*CW-1:FB]));
        end
        r_s5_t     <= r_s4_t;
        r_s5_front <= r_s4_front;
        r_s5_miss  <= r_s4_miss;
    end

    // stage 6: bounds, texture operands, saturation of the normal coordinate
    logic signed [PW-1:0] pa, pb, pn, flo, fhi, slo, shi, du, dv;
    logic signed [PW-1:0] sat_hi, sat_lo;
    logic signed [CW:0]   fspan, sspan;
    logic                 n_s6_out;
    logic [CW-1:0]        pn_sat;
    logic [2:0][CW-1:0]   p_out;

    assign pa     = $signed(r_s5_p[ax_a]);
    assign pb     = $signed(r_s5_p[ax_b]);
    assign pn     = $signed(r_s5_p[ax_n]);
    assign flo    = PW'($signed(first_lo));
    assign fhi    = PW'($signed(first_hi));
    assign slo    = PW'($signed(second_lo));
    assign shi    = PW'($signed(second_hi));
    assign du     = pa - flo;
    assign dv     = pb - slo;
    assign fspan  = $signed({first_hi[CW-1], first_hi}) - $signed({first_lo[CW-1], first_lo});
    assign sspan  = $signed({second_hi[CW-1], second_hi}) -
                    $signed({second_lo[CW-1], second_lo});
    assign sat_hi = PW'($signed({1'b0, {(CW-1){1'b1}}}));
    assign sat_lo = PW'($signed({1'b1, {(CW-1){1'b0}}}));
    assign n_s6_out = (pa < flo) || (pa > fhi) || (pb < slo) || (pb > shi);
    assign pn_sat = (pn > sat_hi) ? sat_hi[CW-1:0] :
                    (pn < sat_lo) ? sat_lo[CW-1:0] : pn[CW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_out[i] = r_s5_p[i][CW-1:0];
        end
        p_out[ax_n] = pn_sat;
    end

    logic              r_s6_vld;
    logic [DIV_NW-1:0] r_s6_unum, r_s6_vnum;
    logic [DIV_DW-1:0] r_s6_uden, r_s6_vden;
    t_side_tex         r_s6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_unum        <= DIV_NW'(du[CW-1:0]) << TEX_FB;
        r_s6_vnum        <= DIV_NW'(dv[CW-1:0]) << TEX_FB;
        r_s6_uden        <= DIV_DW'(fspan);
        r_s6_vden        <= DIV_DW'(sspan);
        r_s6_side.t      <= r_s5_t;
        r_s6_side.p      <= p_out;
        r_s6_side.front  <= r_s5_front;
        r_s6_side.miss   <= r_s5_miss || n_s6_out;
        r_s6_side.u_zero <= (first_hi == first_lo);
        r_s6_side.v_zero <= (second_hi == second_lo);
    end

    logic              u_vld, v_vld;
    logic [DIV_NW-1:0] u_quo, v_quo;

    rri_div u_div_u (
        .i_clk, .i_rst_n, .i_valid(r_s6_vld), .i_num(r_s6_unum), .i_den(r_s6_uden),
        .o_valid(u_vld), .o_quo(u_quo)
    );

    rri_div u_div_v (
        .i_clk, .i_rst_n, .i_valid(r_s6_vld), .i_num(r_s6_vnum), .i_den(r_s6_vden),
        .o_valid(v_vld), .o_quo(v_quo)
    );

    t_side_tex r_sd2 [DIV_NW];
    always_ff @(posedge i_clk) begin
        r_sd2[0] <= r_s6_side;
        for (int k = 1; k < DIV_NW; k++) begin
            r_sd2[k] <= r_sd2[k-1];
        end
    end

    // output register, a miss clears every field
    t_side_tex sd2;
    assign sd2 = r_sd2[DIV_NW-1];

    logic               r_done, r_hit, r_front;
    logic [CW-1:0]      r_t;
    logic [TEX_W-1:0]   r_u, r_v;
    logic [2:0][CW-1:0] r_p;
    logic [MAT_W-1:0]   r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= u_vld && v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= !sd2.miss;
        r_t     <= sd2.miss ? '0 : sd2.t;
        r_u     <= (sd2.miss || sd2.u_zero) ? '0 : u_quo[TEX_W-1:0];
        r_v     <= (sd2.miss || sd2.v_zero) ? '0 : v_quo[TEX_W-1:0];
        r_p     <= sd2.miss ? '0 : sd2.p;
        r_front <= sd2.miss ? 1'b0 : sd2.front;
        r_mat   <= sd2.miss ? '0 : material;
    end

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_hit_t        = r_t;
    assign o_tex_u        = r_u;
    assign o_tex_v        = r_v;
    assign o_point_x      = r_p[0];
    assign o_point_y      = r_p[1];
    assign o_point_z      = r_p[2];
    assign o_front_face   = r_front;
    assign o_hit_material = r_mat;

endmodule

// ===== design/rri_chk.sv =====
// ----------------------------------------------------------------------------
// rri_chk
// Port-level checks for the ray / rectangle intersection unit.
// ----------------------------------------------------------------------------
module rri_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       busy,
    input logic                       o_done,
    input logic                       o_hit,
    input logic [rri_pkg::CW-1:0]     o_hit_t,
    input logic [rri_pkg::TEX_W-1:0]  o_tex_u,
    input logic [rri_pkg::TEX_W-1:0]  o_tex_v,
    input logic [rri_pkg::CW-1:0]     o_point_x,
    input logic [rri_pkg::CW-1:0]     o_point_y,
    input logic [rri_pkg::CW-1:0]     o_point_z,
    input logic                       o_front_face,
    input logic [rri_pkg::MAT_W-1:0]  o_hit_material
);
    import rri_pkg::*;

    localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1) << TEX_FB;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_hit_t == '0 && o_tex_u == '0 && o_tex_v == '0 &&
            o_point_x == '0 && o_point_y == '0 && o_point_z == '0 &&
            !o_front_face && o_hit_material == '0))
        else $error("miss with non-zero fields");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_tex_u <= TEX_ONE && o_tex_v <= TEX_ONE))
        else $error("tex coordinate above one");

endmodule

bind axis_rect_ray_intersect_unit rri_chk u_rri_chk (.*);
